// ----- hdl/scalar_kalman_angle_filter_macros.svh -----
// assertion macros for the scalar kalman angle filter
// no dependencies; included by the rtl files that carry assertions
`ifndef SCALAR_KALMAN_ANGLE_FILTER_MACROS_SVH
`define SCALAR_KALMAN_ANGLE_FILTER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SKAF_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("skaf assertion failed");

// consequent must hold in the cycle after the antecedent
`define SKAF_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("skaf assertion failed");

`endif

// ----- hdl/skaf_pkg.sv -----
// shared types and constants for the scalar kalman angle filter
// no dependencies; imported by every rtl module of the block
package skaf_pkg;

    // field and register widths
    localparam int NUM_AXES   = 2;
    localparam int AXIS_W     = 1;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int TS_W       = 16;
    localparam int PN_W       = 20;
    localparam int MN_W       = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // serial arithmetic widths
    localparam int GAIN_W = FRAC_BITS + 1;      // gain in [0, 1.0]
    localparam int MC_W   = DATA_W + 2;         // signed multiplicand
    localparam int PROD_W = MC_W + GAIN_W;      // shift-add product
    localparam int DEN_W  = DATA_W + 1;         // divider denominator
    localparam int SUM_W  = DATA_W + 3;         // pre-saturation sums
    localparam int CNT_W  = $clog2(GAIN_W + 1);

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

    // register reset values
    localparam logic [TS_W-1:0]   TIME_STEP_RST  = TS_W'(262);
    localparam logic [PN_W-1:0]   PROC_NOISE_RST = PN_W'(336);
    localparam logic [MN_W-1:0]   MEAS_NOISE_RST = MN_W'(589824);
    localparam logic [DATA_W-1:0] VAR_RST_FIRST  = DATA_W'(4) << FRAC_BITS;
    localparam logic [DATA_W-1:0] VAR_RST_OTHER  = DATA_W'(5) << FRAC_BITS;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_TIME_STEP     = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_PROCESS_NOISE = cfg_idx_t'(1);
    localparam cfg_idx_t CFG_MEAS_NOISE    = cfg_idx_t'(2);

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START1,
        ST_PHASE1,
        ST_PREDICT,
        ST_START2,
        ST_PHASE2,
        ST_FINISH
    } ctrl_state_t;

endpackage

// ----- hdl/skaf_serial_mul.sv -----
// bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier
// depends on skaf_pkg
module skaf_serial_mul
    import skaf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MC_W-1:0]   mcand,
    input  logic        [GAIN_W-1:0] mplier,
    output unit_status_t             status,
    output logic signed [PROD_W-1:0] product
);

    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] mc_reg, mc_next;
    logic [GAIN_W-1:0]        mp_reg, mp_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     done_reg, done_next;

    // one multiplier bit per cycle, lsb first
    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            mc_next  = PROD_W'(mcand);
            mp_next  = mplier;
            cnt_next = CNT_W'(GAIN_W);
        end
        else if (cnt_reg != '0)
        begin
            if (mp_reg[0])
            begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next   = mc_reg <<< 1;
            mp_next   = mp_reg >> 1;
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule

// ----- hdl/skaf_serial_div.sv -----
// bit-serial restoring divider for the kalman gain: (numer << frac) / denom
// depends on skaf_pkg; numer must not exceed denom, a zero denom gives zero
module skaf_serial_div
    import skaf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic        [DATA_W-1:0] numer,
    input  logic        [DEN_W-1:0]  denom,
    output unit_status_t             status,
    output logic        [GAIN_W-1:0] quotient
);

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [GAIN_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              first_reg, first_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    // trial subtract: the first step compares without a shift
    always_comb
    begin
        trial = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // one quotient bit per cycle, msb first
    always_comb
    begin
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = DEN_W'(numer);
            den_next   = denom;
            q_next     = '0;
            cnt_next   = CNT_W'(GAIN_W);
            first_next = 1'b1;
        end
        else if (cnt_reg != '0)
        begin
            rem_next   = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_next     = {q_reg[GAIN_W-2:0], fits};
            cnt_next   = cnt_reg - CNT_W'(1);
            first_next = 1'b0;
            done_next  = (cnt_reg == CNT_W'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quotient    = (den_reg == '0) ? '0 : q_reg;

endmodule

// ----- hdl/scalar_kalman_angle_filter.sv -----
// channel  | handshake                 | payload
// ---------+---------------------------+----------------------------------------------
// item     | item_valid / item_stall   | axis, measured_angle, angular_rate
// result   | result_valid/result_stall | axis_out, filtered_angle, variance_out
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// from accept to result an item makes two passes through the bit-serial units, gain
// divider alongside the rate multiplier, then two correction multipliers, with start,
// predict, start and finish steps around them
// a new item is taken only after the last leaves the finish step, even while a result waits
// a stalled result holds the finish step until the output register is free
// rst_n clears the registers to their defaults and both axis estimates to reset values
// depends on skaf_pkg, skaf_serial_mul, skaf_serial_div and the macros header
`include "scalar_kalman_angle_filter_macros.svh"

module scalar_kalman_angle_filter
    import skaf_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    // item channel
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic        [AXIS_W-1:0]     axis,
    input  logic signed [DATA_W-1:0]     measured_angle,
    input  logic signed [DATA_W-1:0]     angular_rate,
    // result channel
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic        [AXIS_W-1:0]     axis_out,
    output logic signed [DATA_W-1:0]     filtered_angle,
    output logic        [DATA_W-1:0]     variance_out,
    // configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data
);

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

    // round to nearest, ties up, then drop the fraction bits
    function automatic logic signed [SUM_W-1:0] round_frac(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] t;
        t = (p + ROUND_HALF) >>> FRAC_BITS;
        return t[SUM_W-1:0];
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat_s32(
        input logic signed [SUM_W-1:0] x
    );
        logic [SUM_W-DATA_W:0] top;
        top = x[SUM_W-1:DATA_W-1];
        if (top == '0 || top == '1)
        begin
            return x[DATA_W-1:0];
        end
        else if (x[SUM_W-1])
        begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // configuration registers
    logic [TS_W-1:0] time_step_reg;
    logic [PN_W-1:0] proc_noise_reg;
    logic [MN_W-1:0] meas_noise_reg;

    // per-axis estimates
    logic signed [DATA_W-1:0] angle_reg [NUM_AXES];
    logic        [DATA_W-1:0] var_reg   [NUM_AXES];

    // sequencer
    ctrl_state_t state_reg, state_next;

    // item working registers
    logic        [AXIS_W-1:0] ax_reg, ax_next;
    logic signed [DATA_W-1:0] meas_reg, meas_next;
    logic signed [DATA_W-1:0] rate_reg, rate_next;
    logic        [DATA_W-1:0] var_pred_reg, var_pred_next;
    logic signed [DATA_W-1:0] pred_reg, pred_next;

    // result register
    logic                     result_valid_reg, result_valid_next;
    logic        [AXIS_W-1:0] axis_out_reg;
    logic signed [DATA_W-1:0] filtered_angle_reg;
    logic        [DATA_W-1:0] variance_out_reg;

    // arithmetic unit hookup
    logic                     mul_a_start, mul_b_start, div_start;
    logic signed [MC_W-1:0]   mul_a_mcand, mul_b_mcand;
    logic        [GAIN_W-1:0] mul_a_mplier, mul_b_mplier;
    logic signed [PROD_W-1:0] mul_a_prod, mul_b_prod;
    unit_status_t             mul_a_stat, mul_b_stat, div_stat;
    logic        [DEN_W-1:0]  div_denom;
    logic        [GAIN_W-1:0] div_quot;

    // misc combinational
    logic                     item_accept;
    logic                     finish_fire;
    logic        [AXIS_W-1:0] ax_in;
    logic        [DATA_W:0]   var_sum;
    logic signed [SUM_W-1:0]  nvar_full;
    logic signed [DATA_W-1:0] new_angle;
    logic        [DATA_W-1:0] new_var;

    assign cfg_ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_START1;
                end
            end
            ST_START1:
            begin
                state_next = ST_PHASE1;
            end
            ST_PHASE1:
            begin
                if (!mul_a_stat.busy && !div_stat.busy)
                begin
                    state_next = ST_PREDICT;
                end
            end
            ST_PREDICT:
            begin
                state_next = ST_START2;
            end
            ST_START2:
            begin
                state_next = ST_PHASE2;
            end
            ST_PHASE2:
            begin
                if (mul_a_stat.done && mul_b_stat.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item_stall  = 1'b1;
        mul_a_start = 1'b0;
        mul_b_start = 1'b0;
        div_start   = 1'b0;
        finish_fire = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
            end
            ST_START1:
            begin
                mul_a_start = 1'b1;
                div_start   = 1'b1;
            end
            ST_START2:
            begin
                mul_a_start = 1'b1;
                mul_b_start = 1'b1;
            end
            ST_FINISH:
            begin
                finish_fire = !result_valid_reg || !result_stall;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    assign item_accept = item_valid && !item_stall;

    // operand selection for the serial units
    always_comb
    begin
        div_denom    = {1'b0, var_pred_reg} + DEN_W'(meas_noise_reg);
        mul_b_mcand  = {2'b00, var_pred_reg};
        mul_b_mplier = GAIN_ONE - div_quot;
        if (state_reg == ST_START1)
        begin
            mul_a_mcand  = MC_W'(rate_reg);
            mul_a_mplier = GAIN_W'(time_step_reg);
        end
        else
        begin
            mul_a_mcand  = MC_W'(meas_reg) - MC_W'(pred_reg);
            mul_a_mplier = div_quot;
        end
    end

    // item capture and prediction
    always_comb
    begin
        ax_in = (int'(axis) >= NUM_AXES) ? AXIS_W'(NUM_AXES - 1) : axis;
        var_sum = {1'b0, var_reg[ax_in]} + (DATA_W + 1)'(proc_noise_reg);
        ax_next       = ax_reg;
        meas_next     = meas_reg;
        rate_next     = rate_reg;
        var_pred_next = var_pred_reg;
        pred_next     = pred_reg;
        if (item_accept)
        begin
            ax_next       = ax_in;
            meas_next     = measured_angle;
            rate_next     = angular_rate;
            var_pred_next = var_sum[DATA_W] ? '1 : var_sum[DATA_W-1:0];
        end
        if (state_reg == ST_PREDICT)
        begin
            pred_next = sat_s32(SUM_W'(angle_reg[ax_reg]) + round_frac(mul_a_prod));
        end
    end

    // correction results
    always_comb
    begin
        new_angle = sat_s32(SUM_W'(pred_reg) + round_frac(mul_a_prod));
        nvar_full = round_frac(mul_b_prod);
        new_var   = (nvar_full[SUM_W-1:DATA_W] != '0) ? '1 : nvar_full[DATA_W-1:0];
    end

    // result handshake
    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        if (finish_fire)
        begin
            result_valid_next = 1'b1;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            time_step_reg    <= TIME_STEP_RST;
            proc_noise_reg   <= PROC_NOISE_RST;
            meas_noise_reg   <= MEAS_NOISE_RST;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                angle_reg[i] <= '0;
                var_reg[i]   <= (i == 0) ? VAR_RST_FIRST : VAR_RST_OTHER;
            end
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIME_STEP:     time_step_reg  <= cfg_data[TS_W-1:0];
                    CFG_PROCESS_NOISE: proc_noise_reg <= cfg_data[PN_W-1:0];
                    CFG_MEAS_NOISE:    meas_noise_reg <= cfg_data[MN_W-1:0];
                    default:           ;
                endcase
            end
            if (finish_fire)
            begin
                angle_reg[ax_reg] <= new_angle;
                var_reg[ax_reg]   <= new_var;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ax_reg       <= ax_next;
        meas_reg     <= meas_next;
        rate_reg     <= rate_next;
        var_pred_reg <= var_pred_next;
        pred_reg     <= pred_next;
        if (finish_fire)
        begin
            axis_out_reg       <= ax_reg;
            filtered_angle_reg <= new_angle;
            variance_out_reg   <= new_var;
        end
    end

    assign result_valid   = result_valid_reg;
    assign axis_out       = axis_out_reg;
    assign filtered_angle = filtered_angle_reg;
    assign variance_out   = variance_out_reg;

    // rate multiplier, later the gain times innovation
    skaf_serial_mul u_mul_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_a_start),
        .mcand   (mul_a_mcand),
        .mplier  (mul_a_mplier),
        .status  (mul_a_stat),
        .product (mul_a_prod)
    );

    // variance times one minus gain
    skaf_serial_mul u_mul_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_b_start),
        .mcand   (mul_b_mcand),
        .mplier  (mul_b_mplier),
        .status  (mul_b_stat),
        .product (mul_b_prod)
    );

    // kalman gain
    skaf_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (var_pred_reg),
        .denom    (div_denom),
        .status   (div_stat),
        .quotient (div_quot)
    );

    // checks
    `SKAF_ASSERT_NEXT(a_accept_starts, clk, rst_n, item_accept, state_reg == ST_START1)
    `SKAF_ASSERT_SAME(a_gain_in_range, clk, rst_n, state_reg == ST_PREDICT, div_quot <= GAIN_ONE)
    `SKAF_ASSERT_SAME(a_phase1_lockstep, clk, rst_n, state_reg == ST_PHASE1, mul_a_stat.busy == div_stat.busy)
    `SKAF_ASSERT_SAME(a_phase2_lockstep, clk, rst_n, state_reg == ST_PHASE2, mul_a_stat.busy == mul_b_stat.busy)
    `SKAF_ASSERT_NEXT(a_finish_delivers, clk, rst_n, finish_fire, result_valid_reg && state_reg == ST_IDLE)

endmodule

// ----- tb/skaf_filter_checker.sv -----
// scoreboard for the scalar kalman angle filter: watches the item, result and
// cfg channels, predicts each result from its own copy of state, compares fields
// depends on skaf_pkg for widths, register indexes and reset values
`timescale 1ns / 100ps

module skaf_filter_checker
    import skaf_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_stall,
    input  logic        [AXIS_W-1:0]     axis,
    input  logic signed [DATA_W-1:0]     measured_angle,
    input  logic signed [DATA_W-1:0]     angular_rate,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  logic        [AXIS_W-1:0]     axis_out,
    input  logic signed [DATA_W-1:0]     filtered_angle,
    input  logic        [DATA_W-1:0]     variance_out,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data,
    output int unsigned                  mismatches,
    output int unsigned                  outstanding
);

    typedef struct packed {
        logic [AXIS_W-1:0] axis;
        logic [DATA_W-1:0] angle;
        logic [DATA_W-1:0] variance;
    } filter_result_t;

    filter_result_t expected_results[$];
    filter_result_t oldest;

    // shadow of the configuration registers
    logic [TS_W-1:0] step_reg;
    logic [PN_W-1:0] proc_noise_reg;
    logic [MN_W-1:0] meas_noise_reg;

    // shadow of the per-axis estimates
    logic signed [DATA_W-1:0] angle_state    [NUM_AXES];
    logic        [DATA_W-1:0] variance_state [NUM_AXES];

    // drop fraction bits, round to nearest with ties toward plus infinity
    function automatic longint round_q(input longint x);
        return (x + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp_s32(input longint x);
        if (x > longint'(32'sh7FFF_FFFF))
            return longint'(32'sh7FFF_FFFF);
        if (x < longint'(32'sh8000_0000))
            return longint'(32'sh8000_0000);
        return x;
    endfunction

    // one predict/correct step on the selected axis, queues the result it yields
    task automatic predict_update(
        input logic        [AXIS_W-1:0] ax_in,
        input logic signed [DATA_W-1:0] meas,
        input logic signed [DATA_W-1:0] rate
    );
        int             sel;
        longint         pred;
        longint         innov;
        longint         ang;
        logic [63:0]    var_p;
        logic [63:0]    denom;
        logic [63:0]    gain;
        logic [63:0]    var_n;
        filter_result_t res;
        begin
            sel = (int'(ax_in) >= NUM_AXES) ? NUM_AXES - 1 : int'(ax_in);

            // predict
            pred = clamp_s32(longint'(angle_state[sel])
                             + round_q(longint'(rate) * longint'(step_reg)));
            var_p = 64'(variance_state[sel]) + 64'(proc_noise_reg);
            if (var_p > 64'hFFFF_FFFF)
                var_p = 64'hFFFF_FFFF;

            // gain, truncated; zero when the denominator is zero
            denom = var_p + 64'(meas_noise_reg);
            gain  = (denom == 64'd0) ? 64'd0 : (var_p << FRAC_BITS) / denom;

            // correct
            innov = longint'(meas) - pred;
            ang   = clamp_s32(pred + round_q(longint'(gain) * innov));
            var_n = (var_p * ((64'd1 << FRAC_BITS) - gain) + (64'd1 << (FRAC_BITS - 1)))
                    >> FRAC_BITS;
            if (var_n > 64'hFFFF_FFFF)
                var_n = 64'hFFFF_FFFF;

            angle_state[sel]    = DATA_W'(ang);
            variance_state[sel] = DATA_W'(var_n);

            res.axis     = AXIS_W'(sel);
            res.angle    = DATA_W'(ang);
            res.variance = DATA_W'(var_n);
            expected_results.push_back(res);
        end
    endtask

    // result beats first: a result can never come from an item taken in the same cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            step_reg       = TIME_STEP_RST;
            proc_noise_reg = PROC_NOISE_RST;
            meas_noise_reg = MEAS_NOISE_RST;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                angle_state[i]    = '0;
                variance_state[i] = (i == 0) ? VAR_RST_FIRST : VAR_RST_OTHER;
            end
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // compare a result beat against the oldest prediction
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result beat: axis_out %0d filtered_angle %0d variance_out %0d",
                           axis_out, filtered_angle, variance_out);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (axis_out !== oldest.axis)
                    begin
                        $error("axis_out mismatch: expected %0d, actual %0d",
                               oldest.axis, axis_out);
                        mismatches++;
                    end
                    if (filtered_angle !== $signed(oldest.angle))
                    begin
                        $error("filtered_angle mismatch: expected %0d, actual %0d",
                               $signed(oldest.angle), filtered_angle);
                        mismatches++;
                    end
                    if (variance_out !== oldest.variance)
                    begin
                        $error("variance_out mismatch: expected %0d, actual %0d",
                               oldest.variance, variance_out);
                        mismatches++;
                    end
                end
            end

            // item beat
            if (item_valid && !item_stall)
                predict_update(axis, measured_angle, angular_rate);

            // register write; the spare index is ignored
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIME_STEP:     step_reg       = cfg_data[TS_W-1:0];
                    CFG_PROCESS_NOISE: proc_noise_reg = cfg_data[PN_W-1:0];
                    CFG_MEAS_NOISE:    meas_noise_reg = cfg_data[MN_W-1:0];
                    default:           ;
                endcase
            end

            outstanding = expected_results.size();
        end
    end

endmodule

// ----- tb/tb_scalar_kalman_angle_filter.sv -----
// top of the scalar kalman angle filter testbench: clock, reset, stimulus and verdict
// depends on skaf_pkg, the filter rtl and skaf_filter_checker
`timescale 1ns / 100ps

module tb_scalar_kalman_angle_filter
    import skaf_pkg::*;
();

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SEGMENTS      = 6;
    localparam int          SEGMENT_ITEMS = 75;
    localparam int          SETTLE_CYCLES = 60;
    localparam int unsigned ANGLE_SPAN    = 180 << FRAC_BITS;
    localparam int unsigned RATE_SPAN     = 500 << FRAC_BITS;
    localparam int          TS_PAD        = CFG_DATA_W - TS_W;
    localparam int          PN_PAD        = CFG_DATA_W - PN_W;

    localparam cfg_idx_t          CFG_SPARE = cfg_idx_t'(3);
    localparam logic [DATA_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;

    logic                         clk;
    logic                         rst_n          = 1'b0;
    logic                         item_valid     = 1'b0;
    logic                         item_stall;
    logic        [AXIS_W-1:0]     axis           = '0;
    logic signed [DATA_W-1:0]     measured_angle = '0;
    logic signed [DATA_W-1:0]     angular_rate   = '0;
    logic                         result_valid;
    logic                         result_stall   = 1'b0;
    logic        [AXIS_W-1:0]     axis_out;
    logic signed [DATA_W-1:0]     filtered_angle;
    logic        [DATA_W-1:0]     variance_out;
    logic                         cfg_valid      = 1'b0;
    logic                         cfg_ready;
    logic        [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic        [CFG_DATA_W-1:0] cfg_data       = '0;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycle_count = 0;
    logic        quiet       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    scalar_kalman_angle_filter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .axis           (axis),
        .measured_angle (measured_angle),
        .angular_rate   (angular_rate),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .axis_out       (axis_out),
        .filtered_angle (filtered_angle),
        .variance_out   (variance_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    skaf_filter_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .axis           (axis),
        .measured_angle (measured_angle),
        .angular_rate   (angular_rate),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .axis_out       (axis_out),
        .filtered_angle (filtered_angle),
        .variance_out   (variance_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // receiver back-pressure, off during the quiet stretch
    always @(posedge clk)
    begin
        result_stall <= !quiet && ($urandom_range(0, 99) < 38);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] q_deg(input int deg);
        return DATA_W'(deg * (1 << FRAC_BITS));
    endfunction

    // mostly plausible sensor values, some raw words and some extremes
    function automatic logic [DATA_W-1:0] pick_field(input int unsigned span);
        int unsigned sel;
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                return DATA_W'(int'($urandom_range(0, 2 * span)) - int'(span));
            if (sel < 85)
                return $urandom();
            case ($urandom_range(0, 3))
                0:       return Q_MAX;
                1:       return Q_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg(input int unsigned lowest,
                                                       input int unsigned highest);
        int unsigned sel;
        begin
            sel = $urandom_range(0, 99);
            if (sel < 20)
                return CFG_DATA_W'(lowest);
            if (sel < 40)
                return CFG_DATA_W'(highest);
            return CFG_DATA_W'($urandom_range(lowest, highest));
        end
    endfunction

    // entered and left right after a rising edge; valid stays high for a following beat
    task automatic send_item(input logic [AXIS_W-1:0] ax,
                             input logic [DATA_W-1:0] meas,
                             input logic [DATA_W-1:0] rate);
        int unsigned gap;
        begin
            gap = 0;
            if (!quiet && $urandom_range(0, 99) < 38)
                gap = $urandom_range(1, 80);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            item_valid     <= 1'b1;
            axis           <= ax;
            measured_angle <= meas;
            angular_rate   <= rate;
            do
                @(negedge clk);
            while (item_stall);
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            do
                @(negedge clk);
            while (!cfg_ready);
            @(posedge clk);
        end
    endtask

    // unused upper data bits carry junk, the block must ignore them
    task automatic program_filter(input logic [TS_W-1:0] ts,
                                  input logic [PN_W-1:0] pn,
                                  input logic [MN_W-1:0] mn,
                                  input bit              with_spare);
        begin
            if (with_spare)
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
            write_reg(CFG_TIME_STEP, {TS_PAD'($urandom()), ts});
            write_reg(CFG_PROCESS_NOISE, {PN_PAD'($urandom()), pn});
            write_reg(CFG_MEAS_NOISE, mn);
            cfg_valid <= 1'b0;
        end
    endtask

    // hold the sender until every predicted result has been taken
    task automatic drain;
        begin
            item_valid <= 1'b0;
            do
                @(negedge clk);
            while (outstanding != 0);
            @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero, plausible and extreme inputs on both axes
        send_item(1'b0, '0, '0);
        send_item(1'b1, '0, '0);
        send_item(1'b0, q_deg(90), q_deg(10));
        send_item(1'b1, q_deg(-45), q_deg(-20));
        send_item(1'b0, Q_MAX, Q_MAX);
        send_item(1'b1, Q_MIN, Q_MIN);
        drain();

        // largest registers: angle saturation both ways
        program_filter('1, '1, '1, 1'b0);
        send_item(1'b0, Q_MAX, Q_MAX);
        send_item(1'b0, Q_MAX, Q_MAX);
        send_item(1'b1, Q_MIN, Q_MIN);
        send_item(1'b1, Q_MIN, Q_MIN);
        send_item(1'b0, Q_MIN, Q_MAX);
        send_item(1'b1, Q_MAX, Q_MIN);
        drain();

        // all noise zero: full gain once per axis, then a zero denominator; spare index written
        program_filter('0, '0, '0, 1'b1);
        send_item(1'b0, DATA_W'(1000), DATA_W'(5));
        send_item(1'b0, -DATA_W'(1000), DATA_W'(5));
        send_item(1'b1, Q_MAX, '0);
        send_item(1'b1, Q_MIN, '0);
        send_item(1'b0, '0, Q_MAX);
        drain();

        // smallest nonzero registers, alternating bit patterns
        program_filter(TS_W'(1), PN_W'(1), MN_W'(1), 1'b1);
        send_item(1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
        drain();

        // random segments, a new setting each; the second runs with no idling
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 0)
                program_filter(TIME_STEP_RST, PROC_NOISE_RST, MEAS_NOISE_RST, 1'b0);
            else
                program_filter(TS_W'(pick_reg(0, 65535)),
                               PN_W'(pick_reg(0, 1048575)),
                               MN_W'(pick_reg(1, 16777215)),
                               bit'($urandom_range(0, 1)));
            quiet <= (seg == 1);
            for (int i = 0; i < SEGMENT_ITEMS; i++)
            begin
                if (seg == 3 && i == SEGMENT_ITEMS / 2)
                    drain();
                send_item(AXIS_W'($urandom_range(0, 1)),
                          pick_field(ANGLE_SPAN),
                          pick_field(RATE_SPAN));
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/skaf_pkg.sv
hdl/skaf_serial_mul.sv
hdl/skaf_serial_div.sv
hdl/scalar_kalman_angle_filter.sv
tb/skaf_filter_checker.sv
tb/tb_scalar_kalman_angle_filter.sv
